FILE: rtl/bdlp_pkg.sv
// Shared constants, codes and controller/datapath interface types for the button debouncer.
package bdlp_pkg;

  localparam int KEY_COUNT   = 3;
  localparam int QUEUE_DEPTH = 16;

  localparam int KEY_IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam int MODE_W   = 2;
  localparam int KEY_W    = 2;
  localparam int LEVELS_W = 3;
  localparam int CODE_W   = 5;
  localparam int LEVEL_W  = 4;
  localparam int DROP_W   = 2;
  localparam int CFG_W    = 8;
  localparam int CIDX_W   = 2;

  // input modes
  localparam logic [MODE_W-1:0] MODE_PRESS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

  // per-key debounce states
  localparam logic [1:0] KS_UP      = 2'd0;
  localparam logic [1:0] KS_DOWN    = 2'd1;
  localparam logic [1:0] KS_PENDING = 2'd2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_HOLD_THRESHOLD = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SHORT_DELAY    = 2'd1;
  localparam logic [CIDX_W-1:0] REG_LONG_DELAY     = 2'd2;

  localparam logic [CFG_W-1:0]  HOLD_THRESHOLD_RST = 8'd30;
  localparam logic [CFG_W-1:0]  SHORT_DELAY_RST    = 8'd1;
  localparam logic [CFG_W-1:0]  LONG_DELAY_RST     = 8'd10;
  localparam logic [CODE_W-1:0] LONG_FLAG          = 5'h10;
  localparam logic [7:0]        HOLD_MAX           = 8'd255;

  typedef struct packed {
    logic                 capture;   // latch the new transaction
    logic                 exec;      // run a press, pop or clear
    logic                 key_step;  // evaluate one key on a tick
    logic [KEY_IDX_W-1:0] key_idx;
  } bdlp_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
  } bdlp_stat_t;

endpackage

FILE: rtl/bdlp_ctrl.sv
// Sequencing controller: accept, execute or walk the keys, then strobe the result.
module bdlp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  bdlp_pkg::bdlp_stat_t stat,
  output bdlp_pkg::bdlp_cmd_t  cmd,
  output logic                busy,
  output logic                done
);
  import bdlp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_KEY  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]           state, state_next;
  logic [KEY_IDX_W-1:0] key_idx, key_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      key_idx <= '0;
    end else begin
      state   <= state_next;
      key_idx <= key_idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    key_idx_next = key_idx;
    cmd          = '0;
    cmd.key_idx  = key_idx;
    busy         = 1'b1;
    done         = 1'b0;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.mode == MODE_TICK) begin
          key_idx_next = '0;
          state_next   = S_KEY;
        end else begin
          cmd.exec   = 1'b1;
          state_next = S_OUT;
        end
      end
      S_KEY: begin
        cmd.key_step = 1'b1;
        if (key_idx == KEY_IDX_W'(KEY_COUNT - 1)) begin
          state_next = S_OUT;
        end else begin
          key_idx_next = key_idx + 1'b1;
        end
      end
      S_OUT: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/bdlp_datapath.sv
// Datapath: configuration, per-key debounce timers, event ring and result registers.
module bdlp_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  bdlp_pkg::bdlp_cmd_t           cmd,
  output bdlp_pkg::bdlp_stat_t          stat,
  input  logic [bdlp_pkg::MODE_W-1:0]   mode,
  input  logic [bdlp_pkg::KEY_W-1:0]    key,
  input  logic [bdlp_pkg::LEVELS_W-1:0] levels,
  input  logic                          cfg_we,
  input  logic [bdlp_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [bdlp_pkg::CFG_W-1:0]    cfg_data,
  output logic [bdlp_pkg::CODE_W-1:0]   popped_code,
  output logic                          popped_valid,
  output logic [bdlp_pkg::LEVEL_W-1:0]  fifo_level,
  output logic [bdlp_pkg::DROP_W-1:0]   dropped
);
  import bdlp_pkg::*;

  // configuration
  logic [CFG_W-1:0] hold_threshold, short_delay, long_delay;

  // latched transaction
  logic [MODE_W-1:0]   mode_q;
  logic [KEY_W-1:0]    key_q;
  logic [LEVELS_W-1:0] levels_q;

  // per-key state
  logic [1:0] key_state  [KEY_COUNT];
  logic       armed      [KEY_COUNT];
  logic [7:0] countdown  [KEY_COUNT];
  logic [7:0] hold_count [KEY_COUNT];

  // event ring
  logic [CODE_W-1:0] ring [QUEUE_DEPTH];
  logic [PTR_W-1:0]  head, tail;
  logic [CODE_W-1:0] rd_data;
  logic              pop_hit;
  logic [DROP_W-1:0] drops;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // one key evaluated per step
  logic [KEY_IDX_W-1:0] ki;
  logic                 k_expire, k_down, push_req;
  logic [CODE_W-1:0]    push_code, ev_code;
  logic                 ring_full;
  logic                 press_ok;
  logic [KEY_IDX_W-1:0] pk;

  assign ki        = cmd.key_idx;
  assign ev_code   = CODE_W'(ki) + 1'b1;
  assign k_expire  = armed[ki] && !(countdown[ki] > 8'd1);
  assign k_down    = (32'(ki) < LEVELS_W) ? levels_q[ki] : 1'b0;
  assign ring_full = (ring_next(head) == tail);
  assign pk        = key_q[KEY_IDX_W-1:0];
  assign press_ok  = (32'(key_q) < KEY_COUNT) && (key_state[pk] == KS_UP);

  always_comb begin
    push_req  = 1'b0;
    push_code = ev_code;
    if (cmd.key_step && k_expire) begin
      if (k_down) begin
        push_code = ev_code | LONG_FLAG;
        push_req  = (key_state[ki] != KS_PENDING) && (hold_count[ki] == hold_threshold)
                    && (hold_threshold != HOLD_MAX);
      end else begin
        push_req = (hold_count[ki] <= hold_threshold);
      end
    end
  end

  assign stat.mode = mode_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_threshold <= HOLD_THRESHOLD_RST;
      short_delay    <= SHORT_DELAY_RST;
      long_delay     <= LONG_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOLD_THRESHOLD: hold_threshold <= cfg_data;
        REG_SHORT_DELAY:    short_delay    <= cfg_data;
        REG_LONG_DELAY:     long_delay     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q   <= mode;
      key_q    <= key;
      levels_q <= levels;
    end
  end

  // key state machine per key
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_COUNT; i++) begin
        key_state[i]  <= KS_UP;
        armed[i]      <= 1'b0;
        countdown[i]  <= '0;
        hold_count[i] <= '0;
      end
    end else if (cmd.exec && mode_q == MODE_PRESS) begin
      if (press_ok) begin
        key_state[pk] <= KS_PENDING;
        armed[pk]     <= 1'b1;
        countdown[pk] <= short_delay;
      end
    end else if (cmd.key_step && armed[ki]) begin
      if (!k_expire) begin
        countdown[ki] <= countdown[ki] - 1'b1;
      end else if (k_down) begin
        key_state[ki] <= KS_DOWN;
        if (hold_count[ki] != HOLD_MAX) hold_count[ki] <= hold_count[ki] + 1'b1;
        countdown[ki] <= long_delay;
      end else begin
        key_state[ki]  <= KS_UP;
        hold_count[ki] <= '0;
        armed[ki]      <= 1'b0;
        countdown[ki]  <= '0;
      end
    end
  end

  // ring pointers, pop flag and drop count
  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      pop_hit <= 1'b0;
      drops   <= '0;
    end else if (cmd.capture) begin
      pop_hit <= 1'b0;
      drops   <= '0;
    end else if (cmd.exec && mode_q == MODE_CLEAR) begin
      head <= '0;
      tail <= '0;
    end else if (cmd.exec && mode_q == MODE_POP) begin
      if (head != tail) begin
        pop_hit <= 1'b1;
        tail    <= ring_next(tail);
      end
    end else if (push_req) begin
      if (ring_full) begin
        if (drops != '1) drops <= drops + 1'b1;
      end else begin
        head <= ring_next(head);
      end
    end
  end

  // ring storage, registered read
  always_ff @(posedge clk) begin
    if (push_req && !ring_full) ring[head] <= push_code;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && mode_q == MODE_POP) rd_data <= ring[tail];
  end

  logic [PTR_W:0] lvl;
  assign lvl = (head >= tail) ? {1'b0, head} - {1'b0, tail}
                              : {1'b0, head} + (PTR_W+1)'(QUEUE_DEPTH) - {1'b0, tail};

  assign popped_code  = pop_hit ? rd_data : '0;
  assign popped_valid = pop_hit;
  assign fifo_level   = LEVEL_W'(lvl);
  assign dropped      = drops;

endmodule

FILE: rtl/button_debounce_long_press.sv
// Top level of the three-button debouncer with long-press detection and event queue.
//
// Usage: a transaction is taken when start is high and busy is low. For a press
// edge, pop or clear, the controller passes the execute state and then raises
// done in the output state. For a tick, it walks every key in the key state
// before the output state. A tick takes longer because the keys are evaluated
// one per cycle, so that their queue pushes happen in key order through the
// single write port of the event ring. The next transaction can be accepted
// in the cycle after done. The result (popped_code, popped_valid, fifo_level,
// dropped) is valid in the single cycle that done is high and is held until
// the next transaction is accepted; the receiver cannot stall it. busy stays
// high from acceptance through the done cycle. Configuration writes are always
// accepted (cfg_ready is tied high) and should only be issued while idle.
// The ring holds at most QUEUE_DEPTH-1 events; pushes into a full ring are
// discarded and counted in dropped.
module button_debounce_long_press (
  input  logic                          clk,
  input  logic                          rst,
  // command transaction
  input  logic                          start,
  output logic                          busy,
  input  logic [bdlp_pkg::MODE_W-1:0]   mode,
  input  logic [bdlp_pkg::KEY_W-1:0]    key,
  input  logic [bdlp_pkg::LEVELS_W-1:0] levels,
  // result strobe and payload
  output logic                          done,
  output logic [bdlp_pkg::CODE_W-1:0]   popped_code,
  output logic                          popped_valid,
  output logic [bdlp_pkg::LEVEL_W-1:0]  fifo_level,
  output logic [bdlp_pkg::DROP_W-1:0]   dropped,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bdlp_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [bdlp_pkg::CFG_W-1:0]    cfg_data
);
  import bdlp_pkg::*;

  bdlp_cmd_t  cmd;
  bdlp_stat_t stat;

  // register writes are always accepted, so ready is tied high
  assign cfg_ready = 1'b1;

  bdlp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  bdlp_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .mode         (mode),
    .key          (key),
    .levels       (levels),
    .cfg_we       (cfg_valid & cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .popped_code  (popped_code),
    .popped_valid (popped_valid),
    .fifo_level   (fifo_level),
    .dropped      (dropped)
  );

endmodule
